### hdl/ddsp_pkg.sv
package ddsp_pkg;

  localparam int NUM_W     = 32;
  localparam int DIGITS    = 10;
  localparam int DIG_W     = 4;
  localparam int BCD_W     = DIGITS * DIG_W;
  localparam int BITS_STEP = 2;
  localparam int BCD_STEPS = NUM_W / BITS_STEP;

  localparam logic [7:0] MAIN_SLOT_RESET = 8'd51;
  localparam logic [3:0] MAIN_PAL_RESET  = 4'd4;
  localparam logic [3:0] SUB_PAL_RESET   = 4'd0;

  localparam logic [1:0] REG_SLOT_START = 2'd0;
  localparam logic [1:0] REG_MAIN_PAL   = 2'd1;
  localparam logic [1:0] REG_SUB_PAL    = 2'd2;

  typedef struct packed {
    logic       slot_load;
    logic [7:0] slot_start;
    logic [3:0] main_palette;
    logic [3:0] sub_palette;
  } cfg_t;

  function automatic logic [3:0] glyph_width(input logic [3:0] d);
    logic [3:0] w;
    case (d)
      4'd0:    w = 4'd13;
      4'd1:    w = 4'd11;
      4'd2:    w = 4'd12;
      4'd3:    w = 4'd12;
      4'd4:    w = 4'd12;
      4'd5:    w = 4'd13;
      4'd6:    w = 4'd11;
      4'd7:    w = 4'd11;
      4'd8:    w = 4'd10;
      4'd9:    w = 4'd10;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

### hdl/ddsp_bcd.sv
module ddsp_bcd (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ddsp_pkg::NUM_W-1:0] number,
  output logic                       busy,
  output logic                       done,
  output logic [ddsp_pkg::BCD_W-1:0] bcd
);

  logic [ddsp_pkg::NUM_W-1:0] bin;
  logic [3:0]                 cnt;
  logic [ddsp_pkg::BCD_W-1:0] fix1;
  logic [ddsp_pkg::BCD_W-1:0] fix2;
  logic [ddsp_pkg::BCD_W-1:0] bcd_next;

  function automatic logic [ddsp_pkg::BCD_W-1:0] add3(input logic [ddsp_pkg::BCD_W-1:0] v);
    logic [ddsp_pkg::BCD_W-1:0] r;
    r = v;
    for (int i = 0; i < ddsp_pkg::DIGITS; i++) begin
      if (v[i*ddsp_pkg::DIG_W +: ddsp_pkg::DIG_W] >= 4'd5) begin
        r[i*ddsp_pkg::DIG_W +: ddsp_pkg::DIG_W] = v[i*ddsp_pkg::DIG_W +: ddsp_pkg::DIG_W] + 4'd3;
      end
    end
    return r;
  endfunction

  // two bits of the binary value per cycle
  always_comb begin
    fix1     = add3(bcd);
    fix2     = add3({fix1[ddsp_pkg::BCD_W-2:0], bin[ddsp_pkg::NUM_W-1]});
    bcd_next = {fix2[ddsp_pkg::BCD_W-2:0], bin[ddsp_pkg::NUM_W-2]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        bin  <= number;
        bcd  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        bcd <= bcd_next;
        bin <= {bin[ddsp_pkg::NUM_W-ddsp_pkg::BITS_STEP-1:0], {ddsp_pkg::BITS_STEP{1'b0}}};
        cnt <= cnt + 4'd1;
        if (cnt == 4'(ddsp_pkg::BCD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/ddsp_emit.sv
module ddsp_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [7:0]                 anchor_x,
  input  logic [7:0]                 anchor_y,
  input  logic [6:0]                 slot_base,
  input  logic                       screen,
  input  ddsp_pkg::cfg_t             cfg,
  input  logic                       bcd_done,
  input  logic [ddsp_pkg::BCD_W-1:0] bcd,
  output logic                       busy,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 slot,
  output logic signed [9:0]          pos_x,
  output logic [7:0]                 pos_y,
  output logic [3:0]                 digit,
  output logic [3:0]                 palette,
  output logic                       last
);

  typedef enum logic [1:0] {IDLE, WAIT, SWEEP, EMIT} state_t;

  state_t     state;
  logic [7:0] ax;
  logic [7:0] ay;
  logic [6:0] base;
  logic       scr;
  logic [3:0] dig [ddsp_pkg::DIGITS];
  logic [3:0] idx;
  logic       seen;
  logic [3:0] msd;
  logic [6:0] total;
  logic [6:0] total_next;
  logic [9:0] x;
  logic [3:0] k;
  logic [7:0] main_slot;
  logic       out_free;

  assign busy       = (state != IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign total_next = total + (seen ? {3'b000, ddsp_pkg::glyph_width(dig[ddsp_pkg::DIGITS-1])}
                                    : 7'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      m_tvalid  <= 1'b0;
      main_slot <= ddsp_pkg::MAIN_SLOT_RESET;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            ax    <= anchor_x;
            ay    <= anchor_y;
            base  <= slot_base;
            scr   <= screen;
            state <= WAIT;
          end
        end
        WAIT: begin
          if (bcd_done) begin
            for (int i = 0; i < ddsp_pkg::DIGITS; i++) begin
              dig[i] <= bcd[i*ddsp_pkg::DIG_W +: ddsp_pkg::DIG_W];
            end
            idx   <= 4'(ddsp_pkg::DIGITS - 1);
            seen  <= 1'b0;
            msd   <= '0;
            total <= '0;
            state <= SWEEP;
          end
        end
        SWEEP: begin
          // rotate, most significant digit first
          dig[0] <= dig[ddsp_pkg::DIGITS-1];
          for (int i = 1; i < ddsp_pkg::DIGITS; i++) begin
            dig[i] <= dig[i-1];
          end
          total <= total_next;
          if (dig[ddsp_pkg::DIGITS-1] != 4'd0 && !seen) begin
            seen <= 1'b1;
            msd  <= idx;
          end
          idx <= idx - 4'd1;
          if (idx == 4'd0) begin
            x     <= {2'b00, ax} + {3'b000, total_next};
            k     <= '0;
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (scr) begin
              slot <= {1'b0, base} + {4'b0000, k};
            end else begin
              slot      <= main_slot;
              main_slot <= main_slot + 8'd1;
            end
            pos_x   <= x;
            pos_y   <= ay;
            digit   <= dig[0];
            palette <= scr ? cfg.sub_palette : cfg.main_palette;
            last    <= (k == msd);
            x       <= x - {6'b000000, ddsp_pkg::glyph_width(dig[1])};
            for (int i = 0; i < ddsp_pkg::DIGITS - 1; i++) begin
              dig[i] <= dig[i+1];
            end
            k <= k + 4'd1;
            if (k == msd) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
      if (cfg.slot_load) begin
        main_slot <= cfg.slot_start;
      end
    end
  end

endmodule

### hdl/decimal_digit_sprite_placer.sv
// Channel  Dir  Handshake            Contents
// s_       in   s_tvalid/s_tready    number word: anchor, value, slot base; screen in tuser
// m_       out  m_tvalid/m_tready    one sprite word per decimal digit, tlast on the top digit
// APB      in   psel/penable/pready  main_slot_start, main_palette, sub_palette at 0, 4, 8
//
// An item goes through binary to BCD conversion (two bits a cycle), a latch of the digits
// and a digit sweep for the width sum, then one output word a cycle per digit while
// m_tready does not hold an output word.
// The next word is accepted once the last digit sits in the output register.
// Reset is synchronous; it restores the register defaults and the running slot counter.
module decimal_digit_sprite_placer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // anchor_x, anchor_y, number, slot_base, zero pad
  input  logic        s_tuser,   // screen
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // slot, pos_x, pos_y, digit, palette, zero pad
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                       wr;
  logic [7:0]                 slot_start;
  logic [3:0]                 main_palette;
  logic [3:0]                 sub_palette;
  ddsp_pkg::cfg_t             cfg;
  logic                       accept;
  logic                       bcd_busy;
  logic                       bcd_done;
  logic [ddsp_pkg::BCD_W-1:0] bcd;
  logic                       emit_busy;
  logic [7:0]                 slot;
  logic signed [9:0]          pos_x;
  logic [7:0]                 pos_y;
  logic [3:0]                 digit;
  logic [3:0]                 palette;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_start   <= ddsp_pkg::MAIN_SLOT_RESET;
      main_palette <= ddsp_pkg::MAIN_PAL_RESET;
      sub_palette  <= ddsp_pkg::SUB_PAL_RESET;
    end else if (wr) begin
      unique case (paddr[3:2])
        ddsp_pkg::REG_SLOT_START: slot_start   <= pwdata[7:0];
        ddsp_pkg::REG_MAIN_PAL:   main_palette <= pwdata[3:0];
        ddsp_pkg::REG_SUB_PAL:    sub_palette  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ddsp_pkg::REG_SLOT_START: prdata = {24'd0, slot_start};
      ddsp_pkg::REG_MAIN_PAL:   prdata = {28'd0, main_palette};
      ddsp_pkg::REG_SUB_PAL:    prdata = {28'd0, sub_palette};
      default:                  prdata = '0;
    endcase
  end

  assign cfg.slot_load    = wr && (paddr[3:2] == ddsp_pkg::REG_SLOT_START);
  assign cfg.slot_start   = pwdata[7:0];
  assign cfg.main_palette = main_palette;
  assign cfg.sub_palette  = sub_palette;

  assign s_tready = !bcd_busy && !emit_busy;
  assign accept   = s_tvalid && s_tready;

  ddsp_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .number (s_tdata[47:16]),
    .busy   (bcd_busy),
    .done   (bcd_done),
    .bcd    (bcd)
  );

  ddsp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .anchor_x  (s_tdata[7:0]),
    .anchor_y  (s_tdata[15:8]),
    .slot_base (s_tdata[54:48]),
    .screen    (s_tuser),
    .cfg       (cfg),
    .bcd_done  (bcd_done),
    .bcd       (bcd),
    .busy      (emit_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .slot      (slot),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .digit     (digit),
    .palette   (palette),
    .last      (m_tlast)
  );

  assign m_tdata = {6'd0, palette, digit, pos_y, pos_x, slot};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken again right after accept");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[29:26] <= 4'd9))
    else $error("digit out of decimal range");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("digit run broken before last word");

endmodule

### tb/decimal_digit_sprite_placer_tb.sv
module decimal_digit_sprite_placer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic SCR_MAIN = 1'b0;
  localparam logic SCR_SUB  = 1'b1;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0]        slot;
    logic signed [9:0] pos_x;
    logic [7:0]        pos_y;
    logic [3:0]        digit;
    logic [3:0]        palette;
    logic              last;
  } sprite_t;

  typedef struct {
    logic [7:0]  ax;
    logic [7:0]  ay;
    logic [31:0] num;
    logic [6:0]  base;
    logic        scr;
    bit          typed;
    sprite_t     want;
  } number_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // anchor_x, anchor_y, number, slot_base, zero pad
  logic        s_tuser = 1'b0; // screen
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // slot, pos_x, pos_y, digit, palette, zero pad
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          glyph_px [0:9] = '{13, 11, 12, 12, 12, 13, 11, 11, 10, 10};
  logic [7:0]  main_slot_ctr = ddsp_pkg::MAIN_SLOT_RESET;
  logic [3:0]  main_pal = ddsp_pkg::MAIN_PAL_RESET;
  logic [3:0]  sub_pal = ddsp_pkg::SUB_PAL_RESET;
  sprite_t     pending_sprites [$];
  number_row_t number_rows [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          hold_len = 0;
  bit          src_idle = 1'b1;
  bit          snk_idle = 1'b1;

  decimal_digit_sprite_placer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic place_digits(input number_row_t r);
    logic [3:0]  digs [0:9];
    logic [31:0] v;
    int          n;
    int          tot;
    int          x;
    sprite_t     s;
    v = r.num;
    n = 0;
    do begin
      digs[n] = 4'(v % 10);
      v = v / 10;
      n++;
    end while (v != 0 && n < 10);
    tot = 0;
    for (int k = 0; k < n - 1; k++) tot += glyph_px[digs[k]];
    x = r.ax + tot;
    for (int k = 0; k < n; k++) begin
      if (r.scr == SCR_SUB) begin
        s.slot = 8'(r.base + k);
      end else begin
        s.slot = main_slot_ctr;
        main_slot_ctr = main_slot_ctr + 8'd1;
      end
      s.pos_x = x[9:0];
      s.pos_y = r.ay;
      s.digit = digs[k];
      s.palette = (r.scr == SCR_SUB) ? sub_pal : main_pal;
      s.last = (k == n - 1);
      pending_sprites.push_back((r.typed && n == 1) ? r.want : s);
      if (k + 1 < n) x -= glyph_px[digs[k + 1]];
    end
  endtask

  task automatic add_row(input logic [7:0] ax, input logic [7:0] ay, input logic [31:0] num,
                         input logic [6:0] base, input logic scr, input bit typed,
                         input logic [7:0] eslot, input logic signed [9:0] ex,
                         input logic [3:0] edig, input logic [3:0] epal);
    number_row_t r;
    r.ax = ax;
    r.ay = ay;
    r.num = num;
    r.base = base;
    r.scr = scr;
    r.typed = typed;
    r.want = '{slot: eslot, pos_x: ex, pos_y: ay, digit: edig, palette: epal, last: 1'b1};
    number_rows.push_back(r);
  endtask

  function automatic number_row_t rand_row();
    number_row_t r;
    int          k;
    longint      lim;
    r.ax = 8'($urandom_range(0, 255));
    r.ay = 8'($urandom_range(0, 255));
    r.base = 7'($urandom_range(0, 127));
    r.scr = 1'($urandom_range(0, 1));
    r.typed = 1'b0;
    r.want = '0;
    k = $urandom_range(1, 12);
    if (k >= 10) begin
      r.num = $urandom;
    end else begin
      lim = 1;
      repeat (k) lim = lim * 10;
      r.num = 32'($urandom % lim);
    end
    return r;
  endfunction

  task automatic send_number(input number_row_t r);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, r.base, r.num, r.ay, r.ax};
    s_tuser <= r.scr;
    do @(posedge clk); while (!s_tready);
    place_digits(r);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_sprites.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ddsp_pkg::REG_SLOT_START: main_slot_ctr = d[7:0];
      ddsp_pkg::REG_MAIN_PAL:   main_pal = d[3:0];
      ddsp_pkg::REG_SUB_PAL:    sub_pal = d[3:0];
      default: ;
    endcase
  endtask

  task automatic run_random(input int count, input int hold_at, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_len = HOLD_CYCLES;
      if (i == pause_at) drain();
      send_number(rand_row());
    end
    drain();
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    sprite_t got;
    sprite_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[17:8], m_tdata[25:18], m_tdata[29:26], m_tdata[33:30],
             m_tlast};
      if (pending_sprites.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = pending_sprites.pop_front();
        check_field("slot", int'(want.slot), int'(got.slot));
        check_field("pos_x", int'(want.pos_x), int'(got.pos_x));
        check_field("pos_y", int'(want.pos_y), int'(got.pos_y));
        check_field("digit", int'(want.digit), int'(got.digit));
        check_field("palette", int'(want.palette), int'(got.palette));
        check_field("last", int'(want.last), int'(got.last));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_len != 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        m_tready <= 1'b1;
      end else if (snk_idle && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("decimal_digit_sprite_placer_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    add_row(8'd0, 8'd0, 32'd0, 7'd0, SCR_MAIN, 1'b1, 8'd51, 10'sd0, 4'd0,
            ddsp_pkg::MAIN_PAL_RESET);
    add_row(8'd255, 8'd255, 32'd9, 7'd127, SCR_SUB, 1'b1, 8'd127, 10'sd255, 4'd9,
            ddsp_pkg::SUB_PAL_RESET);
    add_row(8'd255, 8'd0, 32'd5, 7'd0, SCR_MAIN, 1'b1, 8'd52, 10'sd255, 4'd5,
            ddsp_pkg::MAIN_PAL_RESET);
    add_row(8'd17, 8'd200, 32'd7, 7'd64, SCR_SUB, 1'b1, 8'd64, 10'sd17, 4'd7,
            ddsp_pkg::SUB_PAL_RESET);
    add_row(8'd255, 8'd255, 32'hFFFF_FFFF, 7'd0, SCR_MAIN, 1'b0, '0, '0, '0, '0);
    add_row(8'd0, 8'd0, 32'hFFFF_FFFF, 7'd127, SCR_SUB, 1'b0, '0, '0, '0, '0);
    add_row(8'd0, 8'd128, 32'd10, 7'd5, SCR_MAIN, 1'b0, '0, '0, '0, '0);
    add_row(8'd3, 8'd1, 32'd1000000000, 7'd118, SCR_SUB, 1'b0, '0, '0, '0, '0);
    add_row(8'd100, 8'd50, 32'd1234567890, 7'd0, SCR_MAIN, 1'b0, '0, '0, '0, '0);
    add_row(8'd200, 8'd60, 32'd987654321, 7'd33, SCR_SUB, 1'b0, '0, '0, '0, '0);
    add_row(8'd1, 8'd2, 32'd4000000000, 7'd0, SCR_MAIN, 1'b0, '0, '0, '0, '0);
    add_row(8'd128, 8'd127, 32'd99, 7'd0, SCR_MAIN, 1'b0, '0, '0, '0, '0);
    add_row(8'd64, 8'd64, 32'd100, 7'd1, SCR_SUB, 1'b0, '0, '0, '0, '0);
    add_row(8'd0, 8'd0, 32'd8, 7'd0, SCR_MAIN, 1'b0, '0, '0, '0, '0);
    add_row(8'd255, 8'd1, 32'd1111111111, 7'd127, SCR_SUB, 1'b0, '0, '0, '0, '0);
    add_row(8'd0, 8'd255, 32'h8000_0000, 7'd0, SCR_MAIN, 1'b0, '0, '0, '0, '0);
    add_row(8'd254, 8'd3, 32'hFFFF_FFFA, 7'd85, SCR_SUB, 1'b0, '0, '0, '0, '0);
    add_row(8'd10, 8'd10, 32'd55555, 7'd42, SCR_SUB, 1'b0, '0, '0, '0, '0);
    add_row(8'd0, 8'd0, 32'd1000, 7'd0, SCR_MAIN, 1'b0, '0, '0, '0, '0);
    add_row(8'd90, 8'd90, 32'd666, 7'd42, SCR_SUB, 1'b0, '0, '0, '0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (number_rows[i]) send_number(number_rows[i]);
    drain();

    write_reg(ddsp_pkg::REG_SLOT_START, 32'd200);
    write_reg(ddsp_pkg::REG_MAIN_PAL, 32'd15);
    write_reg(ddsp_pkg::REG_SUB_PAL, 32'd15);
    run_random(100, 30, 70);

    write_reg(ddsp_pkg::REG_SLOT_START, 32'd0);
    write_reg(ddsp_pkg::REG_MAIN_PAL, 32'd0);
    write_reg(ddsp_pkg::REG_SUB_PAL, 32'd9);
    run_random(90, -1, -1);

    src_idle = 1'b0;
    snk_idle = 1'b0;
    write_reg(ddsp_pkg::REG_SLOT_START, 32'd255);
    write_reg(ddsp_pkg::REG_MAIN_PAL, 32'd7);
    write_reg(ddsp_pkg::REG_SUB_PAL, 32'd1);
    run_random(60, -1, -1);

    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_sprites.size() == 0) begin
      $display("decimal_digit_sprite_placer_tb: done, clean");
    end else begin
      $display("decimal_digit_sprite_placer_tb: done, errors");
    end
    $finish;
  end

endmodule
